// File: rtl/core/kseq_pkg.sv
// Shared types, codes and constants for the terminal key sequence decoder.
package kseq_pkg;

   // Parser modes, one-hot
   typedef enum logic [5:0] {
      MODE_IDLE = 6'b000001,
      MODE_ESC  = 6'b000010,
      MODE_CSI  = 6'b000100,
      MODE_SS2  = 6'b001000,
      MODE_SS3  = 6'b010000,
      MODE_UTF8 = 6'b100000
   } mode_type;

   // Word commands
   localparam logic CMD_BYTE  = 1'b0;
   localparam logic CMD_DRAIN = 1'b1;

   // Special bytes and key code marks
   localparam logic [7:0]  ESC_BYTE      = 8'h1B;
   localparam logic [7:0]  CSI_INTRO     = 8'h5B;
   localparam logic [7:0]  SS2_INTRO     = 8'h4E;
   localparam logic [7:0]  SS3_INTRO     = 8'h4F;
   localparam logic [31:0] CODE_BAD_LEAD = 32'hFFFF_FFFF;
   localparam logic [31:0] CODE_BAD_CONT = 32'hFFFF_FFFE;
   localparam logic [31:0] CSI_MARK      = 32'h4000_0000;
   localparam logic [31:0] SS_MARK       = 32'h8000_0000;
   localparam logic [31:0] ALT_MARK      = 32'hC000_0000;
   localparam logic [31:0] SS3_FLAG      = 32'h0000_0080;
   localparam logic [31:0] ALT_FLAG      = 32'h0000_0100;
   localparam logic [4:0]  CSI_LIMIT     = 5'd24;
   localparam logic [4:0]  CSI_PART_STEP = 5'd5;

   // Parser state
   typedef struct packed {
      mode_type    mode;
      logic [31:0] acc;
      logic [4:0]  shift;
      logic [1:0]  remaining;
      logic        bad;
   } dec_state_type;

   localparam dec_state_type IDLE_STATE = '{
      mode:      MODE_IDLE,
      acc:       32'd0,
      shift:     5'd0,
      remaining: 2'd0,
      bad:       1'b0
   };

   // Outcome of one word
   typedef struct packed {
      logic        emit;
      logic [31:0] key_code;
   } dec_result_type;

endpackage

// File: rtl/core/terminal_key_sequence_decoder_top.sv
// Top level: input register, parser state, decode step and result register.
//
// Decodes a stream of terminal input words (a byte, or an input-drained
// event) into 32-bit key codes: ASCII, UTF-8 code points, CSI sequences,
// SS2/SS3 and ESC-prefixed keys. One word is accepted per cycle, sustained,
// while the result register is free or being taken; a key code appears on
// the result port once the word that completes it has passed from the input
// register through the decode step into the result register.
// Throughput is set by the single parser state register, updated once per
// word. Words that finish no key produce no result. The input side stalls
// only while the input register holds a word and the result register holds
// a word that the receiver is stalling.
module terminal_key_sequence_decoder_top
   import kseq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_command,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_key_code
);

   logic           in_valid_ff, in_valid_in;
   logic           in_cmd_ff;
   logic [7:0]     in_byte_ff;
   dec_state_type  state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [31:0]    rsp_code_ff;
   dec_state_type  step_nxt;
   dec_result_type step_res;
   logic           out_free;
   logic           fire;
   logic           req_take;

   // Handshake control
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   kseq_step u_step (
      .cmd       (in_cmd_ff),
      .data_byte (in_byte_ff),
      .cur       (state_ff),
      .nxt       (step_nxt),
      .res       (step_res)
   );

   // Advance input valid, parser state and result valid
   always_comb begin
      in_valid_in  = req_take ? 1'b1 : (fire ? 1'b0 : in_valid_ff);
      state_in     = fire ? step_nxt : state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (fire && step_res.emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         state_ff     <= IDLE_STATE;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Capture input word
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_cmd_ff  <= req_command;
         in_byte_ff <= req_data_byte;
      end
   end

   // Hold result word until taken
   always_ff @(posedge clock) begin
      if (fire && step_res.emit) begin
         rsp_code_ff <= step_res.key_code;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_key_code = rsp_code_ff;

endmodule

// File: rtl/core/kseq_step.sv
// Single-pass next-state and key code logic for one input word.
module kseq_step
   import kseq_pkg::*;
(
   input  logic           cmd,
   input  logic [7:0]     data_byte,
   input  dec_state_type  cur,
   output dec_state_type  nxt,
   output dec_result_type res
);

   logic [31:0] csi_part;
   logic [31:0] csi_acc;
   logic [1:0]  rem_dec;
   logic        cont_ok;
   logic [31:0] utf_acc;

   // CSI part placed at the current pack position
   always_comb begin
      if (data_byte <= 8'h3F) begin
         csi_part = {24'd0, data_byte - 8'h20};
      end else begin
         csi_part = {24'd0, data_byte - 8'h40};
      end
      csi_acc = cur.acc | (csi_part << cur.shift);
   end

   // UTF-8 continuation accumulate
   always_comb begin
      cont_ok = (data_byte[7:6] == 2'b10);
      utf_acc = {cur.acc[25:0], data_byte[5:0]};
      rem_dec = cur.remaining - 2'd1;
   end

   // Decode one word
   always_comb begin
      nxt = cur;
      res = '{emit: 1'b0, key_code: 32'd0};
      if (cmd == CMD_DRAIN) begin
         nxt = IDLE_STATE;
         unique case (cur.mode)
            MODE_ESC, MODE_SS2, MODE_SS3: begin
               res = '{emit: 1'b1, key_code: 32'd0};
            end
            MODE_CSI: begin
               res = '{emit: 1'b1, key_code: cur.acc};
            end
            MODE_UTF8: begin
               res = '{emit: 1'b1, key_code: CODE_BAD_LEAD};
            end
            default: begin
               res = '{emit: 1'b0, key_code: 32'd0};
            end
         endcase
      end else begin
         unique case (cur.mode)
            MODE_ESC: begin
               if (data_byte == CSI_INTRO) begin
                  nxt.mode  = MODE_CSI;
                  nxt.acc   = CSI_MARK;
                  nxt.shift = 5'd0;
               end else if (data_byte == SS2_INTRO) begin
                  nxt.mode = MODE_SS2;
               end else if (data_byte == SS3_INTRO) begin
                  nxt.mode = MODE_SS3;
               end else begin
                  nxt = IDLE_STATE;
                  res = '{emit: 1'b1,
                          key_code: ALT_MARK | ALT_FLAG | {24'd0, data_byte}};
               end
            end
            MODE_CSI: begin
               if (cur.shift >= CSI_LIMIT) begin
                  // too long: drop this byte and flush
                  nxt = IDLE_STATE;
                  res = '{emit: 1'b1, key_code: cur.acc};
               end else if (data_byte >= 8'h20 && data_byte <= 8'h3F) begin
                  nxt.acc   = csi_acc;
                  nxt.shift = cur.shift + CSI_PART_STEP;
               end else if (data_byte >= 8'h40 && data_byte <= 8'h7E) begin
                  nxt = IDLE_STATE;
                  res = '{emit: 1'b1, key_code: csi_acc};
               end
            end
            MODE_SS2: begin
               nxt = IDLE_STATE;
               res = '{emit: 1'b1, key_code: SS_MARK | {24'd0, data_byte}};
            end
            MODE_SS3: begin
               nxt = IDLE_STATE;
               res = '{emit: 1'b1,
                       key_code: SS_MARK | SS3_FLAG | {24'd0, data_byte}};
            end
            MODE_UTF8: begin
               if (rem_dec == 2'd0) begin
                  nxt = IDLE_STATE;
                  if (cur.bad || !cont_ok) begin
                     res = '{emit: 1'b1, key_code: CODE_BAD_CONT};
                  end else begin
                     res = '{emit: 1'b1, key_code: utf_acc};
                  end
               end else begin
                  nxt.remaining = rem_dec;
                  if (cont_ok) begin
                     nxt.acc = utf_acc;
                  end else begin
                     nxt.bad = 1'b1;
                  end
               end
            end
            default: begin
               // idle: ASCII, ESC or a UTF-8 lead byte
               nxt = IDLE_STATE;
               if (data_byte == ESC_BYTE) begin
                  nxt.mode = MODE_ESC;
               end else if (data_byte[7] == 1'b0) begin
                  res = '{emit: 1'b1, key_code: {24'd0, data_byte}};
               end else if (data_byte[7:5] == 3'b110) begin
                  nxt.mode      = MODE_UTF8;
                  nxt.acc       = {27'd0, data_byte[4:0]};
                  nxt.remaining = 2'd1;
               end else if (data_byte[7:4] == 4'b1110) begin
                  nxt.mode      = MODE_UTF8;
                  nxt.acc       = {28'd0, data_byte[3:0]};
                  nxt.remaining = 2'd2;
               end else if (data_byte[7:3] == 5'b11110) begin
                  nxt.mode      = MODE_UTF8;
                  nxt.acc       = {29'd0, data_byte[2:0]};
                  nxt.remaining = 2'd3;
               end else begin
                  res = '{emit: 1'b1, key_code: CODE_BAD_LEAD};
               end
            end
         endcase
      end
   end

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the terminal key sequence decoder.
module tb_top
   import kseq_pkg::*;
();

   // CSI byte classes and the ASCII ceiling
   localparam logic [7:0] PARAM_LO  = 8'h20;
   localparam logic [7:0] PARAM_HI  = 8'h3F;
   localparam logic [7:0] FINAL_LO  = 8'h40;
   localparam logic [7:0] FINAL_HI  = 8'h7E;
   localparam logic [7:0] ASCII_MAX = 8'h7F;
   localparam int         WORD_GOAL = 1150;

   typedef struct packed {
      logic       command;
      logic [7:0] data;
   } term_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_command = CMD_BYTE;
   logic [7:0]  req_data_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_key_code;

   term_word_type word_q[$];
   logic [31:0]   pending_keys[$];
   int            stim_total = WORD_GOAL;
   int            words_taken = 0;
   int            err_count = 0;

   // Decoder mirror state
   mode_type    dec_mode = MODE_IDLE;
   logic [31:0] dec_acc = '0;
   logic [4:0]  dec_shift = '0;
   logic [1:0]  dec_remaining = '0;
   logic        dec_bad = 1'b0;

   logic          key_hit;
   logic [31:0]   key_val;
   term_word_type next_word;
   logic [31:0]   want_key;

   terminal_key_sequence_decoder_top DUT (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_command   (req_command),
      .req_data_byte (req_data_byte),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_key_code  (rsp_key_code)
   );

   always #5 clock = ~clock;

   // Idle percentage per side: sender light first, then receiver light, then none
   function automatic int idle_pct(input bit sender);
      if (words_taken < stim_total / 3) begin
         return sender ? 20 : 74;
      end else if (words_taken < (2 * stim_total) / 3) begin
         return sender ? 74 : 20;
      end
      return 0;
   endfunction

   // Advance the decoder mirror by one word; report the key code it finishes
   task automatic decode_word(input logic cmd, input logic [7:0] b,
                              output logic hit, output logic [31:0] code);
      logic [31:0] bx;
      bx = {24'd0, b};
      hit = 1'b0;
      code = '0;
      if (cmd == CMD_DRAIN) begin
         case (dec_mode)
            MODE_ESC, MODE_SS2, MODE_SS3: begin
               hit = 1'b1;
               code = '0;
            end
            MODE_CSI: begin
               hit = 1'b1;
               code = dec_acc;
            end
            MODE_UTF8: begin
               hit = 1'b1;
               code = CODE_BAD_LEAD;
            end
            default: ;
         endcase
      end else begin
         case (dec_mode)
            MODE_ESC: begin
               if (b == CSI_INTRO) begin
                  dec_mode = MODE_CSI;
                  dec_acc = CSI_MARK;
                  dec_shift = '0;
               end else if (b == SS2_INTRO) begin
                  dec_mode = MODE_SS2;
               end else if (b == SS3_INTRO) begin
                  dec_mode = MODE_SS3;
               end else begin
                  hit = 1'b1;
                  code = ALT_MARK | ALT_FLAG | bx;
               end
            end
            MODE_CSI: begin
               // Too long: drop this byte and flush what was packed
               if (dec_shift >= CSI_LIMIT) begin
                  hit = 1'b1;
                  code = dec_acc;
               end else if (b >= PARAM_LO && b <= PARAM_HI) begin
                  dec_acc = dec_acc | ((bx - {24'd0, PARAM_LO}) << dec_shift);
                  dec_shift = dec_shift + CSI_PART_STEP;
               end else if (b >= FINAL_LO && b <= FINAL_HI) begin
                  hit = 1'b1;
                  code = dec_acc | ((bx - {24'd0, FINAL_LO}) << dec_shift);
               end
            end
            MODE_SS2: begin
               hit = 1'b1;
               code = SS_MARK | bx;
            end
            MODE_SS3: begin
               hit = 1'b1;
               code = SS_MARK | SS3_FLAG | bx;
            end
            MODE_UTF8: begin
               if (b[7:6] == 2'b10) begin
                  dec_acc = {dec_acc[25:0], b[5:0]};
               end else begin
                  dec_bad = 1'b1;
               end
               dec_remaining = dec_remaining - 2'd1;
               if (dec_remaining == 2'd0) begin
                  hit = 1'b1;
                  code = dec_bad ? CODE_BAD_CONT : dec_acc;
               end
            end
            default: begin
               if (b == ESC_BYTE) begin
                  dec_mode = MODE_ESC;
               end else if (b <= ASCII_MAX) begin
                  hit = 1'b1;
                  code = bx;
               end else if (b[7:5] == 3'b110) begin
                  dec_acc = {27'd0, b[4:0]};
                  dec_remaining = 2'd1;
                  dec_bad = 1'b0;
                  dec_mode = MODE_UTF8;
               end else if (b[7:4] == 4'b1110) begin
                  dec_acc = {28'd0, b[3:0]};
                  dec_remaining = 2'd2;
                  dec_bad = 1'b0;
                  dec_mode = MODE_UTF8;
               end else if (b[7:3] == 5'b11110) begin
                  dec_acc = {29'd0, b[2:0]};
                  dec_remaining = 2'd3;
                  dec_bad = 1'b0;
                  dec_mode = MODE_UTF8;
               end else begin
                  hit = 1'b1;
                  code = CODE_BAD_LEAD;
               end
            end
         endcase
      end
      // Any finished key, or a drain, returns the parser to idle
      if (hit || cmd == CMD_DRAIN) begin
         dec_mode = MODE_IDLE;
         dec_acc = '0;
         dec_shift = '0;
         dec_remaining = '0;
         dec_bad = 1'b0;
      end
   endtask

   task automatic push_byte(input logic [7:0] b);
      word_q.push_back('{command: CMD_BYTE, data: b});
   endtask

   task automatic push_drain();
      word_q.push_back('{command: CMD_DRAIN, data: 8'($urandom_range(0, 255))});
   endtask

   // Byte that a CSI sequence skips: control range or above the final range
   function automatic logic [7:0] csi_ignored();
      int r;
      r = $urandom_range(0, 160);
      return (r < 32) ? 8'(r) : 8'(r - 32 + 8'h7F);
   endfunction

   // Queue one random key sequence, mostly well formed
   task automatic push_random_key();
      int pick;
      int len;
      int n;
      int tail;
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
         push_byte(8'($urandom_range(0, 127)));
      end else if (pick < 35) begin
         len = $urandom_range(1, 3);
         case (len)
            1: push_byte({3'b110, 5'($urandom_range(0, 31))});
            2: push_byte({4'b1110, 4'($urandom_range(0, 15))});
            default: push_byte({5'b11110, 3'($urandom_range(0, 7))});
         endcase
         for (int i = 0; i < len; i++) begin
            tail = $urandom_range(0, 99);
            if (tail < 6) begin
               push_drain();
               break;
            end else if (tail < 16) begin
               push_byte(8'($urandom_range(0, 255)));
            end else begin
               push_byte({2'b10, 6'($urandom_range(0, 63))});
            end
         end
      end else if (pick < 40) begin
         if ($urandom_range(0, 1) == 0) begin
            push_byte({2'b10, 6'($urandom_range(0, 63))});
         end else begin
            push_byte({5'b11111, 3'($urandom_range(0, 7))});
         end
      end else if (pick < 65) begin
         push_byte(ESC_BYTE);
         push_byte(CSI_INTRO);
         n = $urandom_range(0, 6);
         for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 9) == 0) begin
               push_byte(csi_ignored());
            end
            push_byte(8'($urandom_range(PARAM_LO, PARAM_HI)));
         end
         tail = $urandom_range(0, 9);
         if (tail < 8) begin
            push_byte(8'($urandom_range(FINAL_LO, FINAL_HI)));
         end else if (tail == 8) begin
            push_drain();
         end else begin
            push_byte(8'($urandom_range(0, 255)));
         end
      end else if (pick < 80) begin
         push_byte(ESC_BYTE);
         push_byte(($urandom_range(0, 1) == 0) ? SS2_INTRO : SS3_INTRO);
         if ($urandom_range(0, 99) < 85) begin
            push_byte(8'($urandom_range(0, 255)));
         end else begin
            push_drain();
         end
      end else if (pick < 90) begin
         push_byte(ESC_BYTE);
         if ($urandom_range(0, 9) < 8) begin
            push_byte(8'($urandom_range(0, 255)));
         end else begin
            push_drain();
         end
      end else if (pick < 95) begin
         push_drain();
      end else begin
         push_byte(8'($urandom_range(0, 255)));
      end
   endtask

   // Fill the word queue, release reset, wait for the last key code
   initial begin
      // ASCII extremes and a drain with nothing pending
      push_byte(8'h00);
      push_byte(ASCII_MAX);
      push_drain();
      // ESC followed by a plain byte, then SS2 and SS3
      push_byte(ESC_BYTE);
      push_byte(8'hFF);
      push_byte(ESC_BYTE);
      push_byte(SS2_INTRO);
      push_byte(8'h00);
      push_byte(ESC_BYTE);
      push_byte(SS3_INTRO);
      push_byte(FINAL_HI);
      // CSI with parameter extremes, a skipped control byte and a final byte
      push_byte(ESC_BYTE);
      push_byte(CSI_INTRO);
      push_byte(PARAM_LO);
      push_byte(PARAM_HI);
      push_byte(8'h0A);
      push_byte(FINAL_HI);
      // Four-byte UTF-8, a bad lead byte, then a bad continuation
      push_byte(8'hF0);
      push_byte(8'h9F);
      push_byte(8'h98);
      push_byte(8'h80);
      push_byte(8'h80);
      push_byte(8'hE2);
      push_byte(8'h41);
      push_byte(8'h82);
      // Drain right after ESC
      push_byte(ESC_BYTE);
      push_drain();

      while (word_q.size() < WORD_GOAL) begin
         push_random_key();
      end
      stim_total = word_q.size();

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Wait for every word to be taken, then for every key code
      do @(posedge clock); while (word_q.size() != 0 || req_valid);
      while (pending_keys.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (err_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // Drive words; hold a stalled word, predict each accepted one
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            decode_word(req_command, req_data_byte, key_hit, key_val);
            if (key_hit) begin
               pending_keys.push_back(key_val);
            end
            words_taken++;
         end
         if (req_valid && req_stall) begin
            // hold
         end else if (word_q.size() != 0 && $urandom_range(0, 99) >= idle_pct(1'b1)) begin
            next_word = word_q.pop_front();
            req_valid <= 1'b1;
            req_command <= next_word.command;
            req_data_byte <= next_word.data;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Check each accepted key code against the oldest prediction; stall at random
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
            if (pending_keys.size() == 0) begin
               $display("%0t: unexpected key code: expected none, actual %h",
                        $time, rsp_key_code);
               err_count++;
            end else begin
               want_key = pending_keys.pop_front();
               if (rsp_key_code !== want_key) begin
                  $display("%0t: key_code mismatch: expected %h, actual %h",
                           $time, want_key, rsp_key_code);
                  err_count++;
               end
            end
         end
         rsp_stall <= ($urandom_range(0, 99) < idle_pct(1'b0));
      end
   end

   // Give up on a hung run
   initial begin
      #2_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
